[sv/bsc_pkg.sv]
// Shared types and constants for the banker's safety checker.
// No dependencies; the top level imports this package.
package bsc_pkg;

  localparam int DEF_MAX_PROCESSES = 16;
  localparam int DEF_MAX_RESOURCES = 16;
  localparam int DEF_COUNT_BITS    = 16;

  localparam int CFG_W       = 5;
  localparam int CFG_RESET   = 16;
  localparam int ID_W        = 4;
  localparam int AMOUNT_W    = 16;

  typedef enum logic [1:0] {
    CMD_LOAD      = 2'd0,
    CMD_SET_AVAIL = 2'd1,
    CMD_REQUEST   = 2'd2,
    CMD_CHECK     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    STS_ACCEPT = 3'd0,
    STS_SEQ    = 3'd1,
    STS_UNSAFE = 3'd2,
    STS_DENIED = 3'd3,
    STS_BAD    = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    CFG_NUM_PROC = 1'b0,
    CFG_NUM_RES  = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REQ_CHK,
    S_REQ_UPD,
    S_CHK_INIT,
    S_CHK_NEXT,
    S_CHK_FIT,
    S_CHK_ADD,
    S_EMIT
  } state_e;

  typedef struct packed {
    cmd_e                  command;
    logic [ID_W-1:0]       process_id;
    logic [ID_W-1:0]       resource_id;
    logic [AMOUNT_W-1:0]   amount;
    logic [AMOUNT_W-1:0]   maximum_claim;
    logic                  last_element;
  } req_t;

  typedef struct packed {
    status_e               status;
    logic [ID_W-1:0]       seq_process;
    logic                  last;
  } res_t;

endpackage

[sv/bsc_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module bsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[sv/bankers_safety_checker.sv]
// Banker's safety checker top level: command decode, table sweeps and results.
// Depends on bsc_pkg and bsc_ram (allocation and need table memory).
// Load, set-available and non-final request items leave busy low. A check sweeps the
// tables at one table read per cycle, then emits np safe-sequence results or one unsafe
// result; a final request element first runs a check sweep and, if granted, an update sweep.
// Results cannot be stalled. Reset clears control state; tables are undefined until written.
module bankers_safety_checker
  import bsc_pkg::*;
#(
  parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
  parameter int MAX_RESOURCES = DEF_MAX_RESOURCES,
  parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  output logic             result_strobe_o,
  output res_t             result_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  cfg_idx_e         cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int PB    = $clog2(MAX_PROCESSES);
  localparam int RB    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int PCW   = $clog2(MAX_PROCESSES + 1);
  localparam int RCW   = $clog2(MAX_RESOURCES + 1);
  localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = COUNT_BITS;
  // A work element holds far more than any need, so its sum saturates at the top.
  localparam int WW    = COUNT_BITS + $clog2(MAX_PROCESSES);

  // Configuration registers hold the raw value; the clamped counts are derived.
  logic [CFG_W-1:0] num_proc_q, num_res_q;
  logic [PCW-1:0]   np_eff;
  logic [RCW-1:0]   nr_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_proc_q <= CFG_W'(CFG_RESET);
      num_res_q  <= CFG_W'(CFG_RESET);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_NUM_PROC: num_proc_q <= cfg_data_i;
        CFG_NUM_RES:  num_res_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero count acts as one and anything above the maximum acts as the maximum.
  always_comb begin
    if (num_proc_q == '0) begin
      np_eff = PCW'(1);
    end else if (32'(num_proc_q) > MAX_PROCESSES) begin
      np_eff = PCW'(MAX_PROCESSES);
    end else begin
      np_eff = PCW'(num_proc_q);
    end
    if (num_res_q == '0) begin
      nr_eff = RCW'(1);
    end else if (32'(num_res_q) > MAX_RESOURCES) begin
      nr_eff = RCW'(MAX_RESOURCES);
    end else begin
      nr_eff = RCW'(num_res_q);
    end
  end

  // State.
  state_e          state_q, state_d;
  logic [CW-1:0]   avail_q [MAX_RESOURCES];
  logic [CW-1:0]   avail_d [MAX_RESOURCES];
  logic [CW-1:0]   rqbuf_q [MAX_RESOURCES];
  logic [CW-1:0]   rqbuf_d [MAX_RESOURCES];
  logic [WW-1:0]   work_q  [MAX_RESOURCES];
  logic [WW-1:0]   work_d  [MAX_RESOURCES];
  logic [PB-1:0]   seq_q   [MAX_PROCESSES];
  logic [PB-1:0]   seq_d   [MAX_PROCESSES];
  logic [MAX_PROCESSES-1:0] fin_q, fin_d;
  logic [PCW-1:0]  proc_q, proc_d;
  logic [PCW-1:0]  done_q, done_d;
  logic [PCW-1:0]  pass_q, pass_d;
  logic [PB-1:0]   emit_q, emit_d;
  logic [RCW-1:0]  iss_q, iss_d;
  logic            pend_q;
  logic [RB-1:0]   pidx_q;
  logic            fit_q, fit_d;
  logic            res_vld_q, res_vld_d;
  res_t            res_q, res_d;

  // Table memory: each entry packs allocation above need.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [2*CW-1:0] ram_wdata, ram_rdata;
  logic [CW-1:0]   rd_alloc, rd_need;

  bsc_ram #(
    .WIDTH(2 * CW),
    .DEPTH(DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_alloc = ram_rdata[2*CW-1:CW];
  assign rd_need  = ram_rdata[CW-1:0];

  // Input decode shared by the next-state and the datapath blocks.
  logic          accept;
  logic          item_bad;
  logic          load_bad;
  logic [CW-1:0] in_amount, in_maxc;
  logic [PB-1:0] in_pid;
  logic [RB-1:0] in_rid;

  assign busy      = (state_q != S_IDLE);
  assign accept    = start && !busy;
  assign in_amount = CW'(req_i.amount);
  assign in_maxc   = CW'(req_i.maximum_claim);
  assign in_pid    = PB'(req_i.process_id);
  assign in_rid    = RB'(req_i.resource_id);
  assign item_bad  = (32'(req_i.resource_id) >= 32'(nr_eff)) ||
                     ((req_i.command != CMD_SET_AVAIL) &&
                      (32'(req_i.process_id) >= 32'(np_eff)));
  assign load_bad  = item_bad || (in_maxc < in_amount);

  // Sweep over the resources of one process. A read is issued per cycle and its
  // data is handled in the following cycle. Each sweep touches distinct entries, so the
  // write-back of one entry never overlaps a read of the same entry.
  logic sweep_on, issue, sweep_last, viol;
  logic [WW:0] work_sum;

  assign sweep_on   = (state_q == S_REQ_CHK) || (state_q == S_REQ_UPD) ||
                      (state_q == S_CHK_FIT) || (state_q == S_CHK_ADD);
  assign issue      = sweep_on && (iss_q < nr_eff);
  assign sweep_last = pend_q && (RCW'(pidx_q) == nr_eff - RCW'(1));
  assign ram_raddr  = AW'(32'(proc_q[PB-1:0]) * MAX_RESOURCES + 32'(iss_q[RB-1:0]));
  assign work_sum   = {1'b0, work_q[pidx_q]} + (WW+1)'(rd_alloc);

  always_comb begin
    viol = 1'b0;
    if (state_q == S_REQ_CHK) begin
      viol = (rqbuf_q[pidx_q] > rd_need) || (rqbuf_q[pidx_q] > avail_q[pidx_q]);
    end else if (state_q == S_CHK_FIT) begin
      viol = WW'(rd_need) > work_q[pidx_q];
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_i.command == CMD_CHECK) begin
            state_d = S_CHK_INIT;
          end else if (req_i.command == CMD_REQUEST && !item_bad &&
                       req_i.last_element) begin
            state_d = S_REQ_CHK;
          end
        end
      end
      S_REQ_CHK: begin
        if (sweep_last) begin
          state_d = (fit_q && !viol) ? S_REQ_UPD : S_IDLE;
        end
      end
      S_REQ_UPD: begin
        if (sweep_last) begin
          state_d = S_CHK_INIT;
        end
      end
      S_CHK_INIT: state_d = S_CHK_NEXT;
      S_CHK_NEXT: begin
        if (done_q == np_eff) begin
          state_d = S_EMIT;
        end else if (pass_q == np_eff) begin
          state_d = S_IDLE;
        end else if (proc_q != np_eff && !fin_q[proc_q[PB-1:0]]) begin
          state_d = S_CHK_FIT;
        end
      end
      S_CHK_FIT: begin
        if (sweep_last) begin
          state_d = (fit_q && !viol) ? S_CHK_ADD : S_CHK_NEXT;
        end
      end
      S_CHK_ADD: begin
        if (sweep_last) begin
          state_d = S_CHK_NEXT;
        end
      end
      S_EMIT: begin
        if (PCW'(emit_q) == np_eff - PCW'(1)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and results.
  always_comb begin
    avail_d   = avail_q;
    rqbuf_d   = rqbuf_q;
    work_d    = work_q;
    seq_d     = seq_q;
    fin_d     = fin_q;
    proc_d    = proc_q;
    done_d    = done_q;
    pass_d    = pass_q;
    emit_d    = emit_q;
    fit_d     = fit_q;
    iss_d     = issue ? iss_q + RCW'(1) : iss_q;
    ram_we    = 1'b0;
    ram_waddr = AW'(32'(proc_q[PB-1:0]) * MAX_RESOURCES + 32'(pidx_q));
    ram_wdata = {rd_alloc + rqbuf_q[pidx_q], rd_need - rqbuf_q[pidx_q]};
    res_vld_d = 1'b0;
    res_d     = '{status: STS_ACCEPT, seq_process: '0, last: 1'b1};

    if (pend_q && viol) begin
      fit_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        iss_d = '0;
        fit_d = 1'b1;
        if (accept) begin
          res_vld_d = 1'b1;
          unique case (req_i.command)
            CMD_LOAD: begin
              if (load_bad) begin
                res_d.status = STS_BAD;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = AW'(32'(in_pid) * MAX_RESOURCES + 32'(in_rid));
                ram_wdata = {in_amount, in_maxc - in_amount};
              end
            end
            CMD_SET_AVAIL: begin
              if (item_bad) begin
                res_d.status = STS_BAD;
              end else begin
                avail_d[in_rid] = in_amount;
              end
            end
            CMD_REQUEST: begin
              if (item_bad) begin
                res_d.status = STS_BAD;
              end else begin
                rqbuf_d[in_rid] = in_amount;
                if (req_i.last_element) begin
                  res_vld_d = 1'b0;
                  proc_d    = PCW'(in_pid);
                end
              end
            end
            CMD_CHECK: res_vld_d = 1'b0;
            default: ;
          endcase
        end
      end
      S_REQ_CHK: begin
        if (sweep_last && !(fit_q && !viol)) begin
          res_vld_d    = 1'b1;
          res_d.status = STS_DENIED;
        end
        if (sweep_last) begin
          iss_d = '0;
          fit_d = 1'b1;
        end
      end
      S_REQ_UPD: begin
        if (pend_q) begin
          ram_we          = 1'b1;
          avail_d[pidx_q] = avail_q[pidx_q] - rqbuf_q[pidx_q];
        end
      end
      S_CHK_INIT: begin
        for (int r = 0; r < MAX_RESOURCES; r++) begin
          work_d[r] = WW'(avail_q[r]);
        end
        fin_d  = '0;
        done_d = '0;
        pass_d = '0;
        proc_d = '0;
        emit_d = '0;
      end
      S_CHK_NEXT: begin
        iss_d = '0;
        fit_d = 1'b1;
        if (done_q == np_eff) begin
          emit_d = '0;
        end else if (pass_q == np_eff) begin
          res_vld_d    = 1'b1;
          res_d.status = STS_UNSAFE;
        end else if (proc_q == np_eff) begin
          pass_d = pass_q + PCW'(1);
          proc_d = '0;
        end else if (fin_q[proc_q[PB-1:0]]) begin
          proc_d = proc_q + PCW'(1);
        end
      end
      S_CHK_FIT: begin
        if (sweep_last) begin
          iss_d = '0;
          if (!(fit_q && !viol)) begin
            proc_d = proc_q + PCW'(1);
          end
        end
      end
      S_CHK_ADD: begin
        // Any value at or above the largest need compares the same, so the sum saturates.
        if (pend_q) begin
          work_d[pidx_q] = work_sum[WW] ? '1 : work_sum[WW-1:0];
        end
        if (sweep_last) begin
          fin_d[proc_q[PB-1:0]] = 1'b1;
          seq_d[done_q[PB-1:0]] = proc_q[PB-1:0];
          done_d                = done_q + PCW'(1);
          proc_d                = proc_q + PCW'(1);
        end
      end
      S_EMIT: begin
        res_vld_d         = 1'b1;
        res_d.status      = STS_SEQ;
        res_d.seq_process = ID_W'(seq_q[emit_q]);
        res_d.last        = (PCW'(emit_q) == np_eff - PCW'(1));
        emit_d            = emit_q + PB'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      res_vld_q <= 1'b0;
      pend_q    <= 1'b0;
      iss_q     <= '0;
      fit_q     <= 1'b1;
      fin_q     <= '0;
      proc_q    <= '0;
      done_q    <= '0;
      pass_q    <= '0;
      emit_q    <= '0;
      work_q    <= '{default: '0};
      seq_q     <= '{default: '0};
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
      pend_q    <= issue;
      iss_q     <= iss_d;
      fit_q     <= fit_d;
      fin_q     <= fin_d;
      proc_q    <= proc_d;
      done_q    <= done_d;
      pass_q    <= pass_d;
      emit_q    <= emit_d;
      work_q    <= work_d;
      seq_q     <= seq_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    avail_q <= avail_d;
    rqbuf_q <= rqbuf_d;
    pidx_q  <= iss_q[RB-1:0];
  end

  assign result_strobe_o = res_vld_q;
  assign result_o        = res_q;

  // Read data is handled only for a read issued the cycle before.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(issue))
    else $error("table data handled without a read");

  // The write-back never targets the entry being read in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && issue) |-> (ram_waddr != ram_raddr))
    else $error("table write collides with read");

  // Safe-sequence results come only out of the emit phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_vld_q && res_q.status == STS_SEQ) |-> ($past(state_q) == S_EMIT))
    else $error("sequence result outside emit phase");

  // An accepted check always leaves the idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req_i.command == CMD_CHECK) |=> busy)
    else $error("check did not start");

endmodule
